/* sv/imt_pkg.sv */
// Shared types, codes and defaults of the interval mask table.
package imt_pkg;

  localparam int NUM_SEQS_DEF  = 4;
  localparam int MAX_AREAS_DEF = 1024;
  localparam int POS_W         = 31;
  localparam int TOTAL_W       = 13;
  localparam int SEQ_CNT_W     = 3;
  localparam int PADDR_W       = 3;
  localparam int PDATA_W       = 32;
  localparam logic [PADDR_W-1:0] ADDR_SEQ_COUNT = 3'd0;
  localparam logic [SEQ_CNT_W-1:0] SEQ_COUNT_RST = 3'd2;

  typedef enum logic [1:0] {
    FN_INSERT  = 2'd0,
    FN_COMPACT = 2'd1,
    FN_QUERY   = 2'd2,
    FN_NOP     = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_ORDER = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]       func;
    logic [1:0]       seq_index;
    logic [POS_W-1:0] begin_req;
    logic [POS_W-1:0] finish;
    logic [POS_W-1:0] query_position;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               masked;
    logic [TOTAL_W-1:0] total_count;
  } res_t;

  typedef struct packed {
    logic [POS_W-1:0] start_pos;
    logic [POS_W-1:0] end_pos;
  } entry_t;

endpackage

/* sv/imt_mem.sv */
// Interval storage: one write port, one read port, registered read data.
module imt_mem #(
  parameter int DEPTH  = imt_pkg::NUM_SEQS_DEF * imt_pkg::MAX_AREAS_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                we,
  input  logic [ADDR_W-1:0]   waddr,
  input  imt_pkg::entry_t     wdata,
  input  logic [ADDR_W-1:0]   raddr,
  output imt_pkg::entry_t     rdata
);

  imt_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/imt_ctrl.sv */
// Sequencer: insert, binary-search query, in-memory insertion sort and merge.
module imt_ctrl #(
  parameter int NUM_SEQS  = imt_pkg::NUM_SEQS_DEF,
  parameter int MAX_AREAS = imt_pkg::MAX_AREAS_DEF,
  parameter int ADDR_W    = $clog2(NUM_SEQS * MAX_AREAS),
  parameter int ACT_W     = $clog2(NUM_SEQS + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [ACT_W-1:0]    act,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  imt_pkg::cmd_t       cmd,
  output logic                done_valid,
  input  logic                done_ready,
  output imt_pkg::res_t       done_res,
  output logic                mem_we,
  output logic [ADDR_W-1:0]   mem_waddr,
  output imt_pkg::entry_t     mem_wdata,
  output logic [ADDR_W-1:0]   mem_raddr,
  input  imt_pkg::entry_t     mem_rdata
);

  localparam int LEN_W = $clog2(MAX_AREAS + 1);
  localparam int IDX_W = $clog2(MAX_AREAS);
  localparam int SEQ_W = (NUM_SEQS > 1) ? $clog2(NUM_SEQS) : 1;
  localparam int TW    = imt_pkg::TOTAL_W;

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_INS    = 14'b00000000000010,
    S_QSTART = 14'b00000000000100,
    S_QTEST  = 14'b00000000001000,
    S_QCHK   = 14'b00000000010000,
    S_CSTART = 14'b00000000100000,
    S_SKGET  = 14'b00000001000000,
    S_SPCHK  = 14'b00000010000000,
    S_SPPUT  = 14'b00000100000000,
    S_MGFST  = 14'b00001000000000,
    S_MGCHK  = 14'b00010000000000,
    S_MGEND  = 14'b00100000000000,
    S_NEXT   = 14'b01000000000000,
    S_DONE   = 14'b10000000000000
  } state_t;

  state_t                 state;
  imt_pkg::cmd_t          item;
  logic [SEQ_W-1:0]       cur_seq;
  logic [LEN_W-1:0]       lengths [NUM_SEQS];
  logic [TW-1:0]          total;
  logic [LEN_W-1:0]       i, j, n, w, lo, hi, mid;
  imt_pkg::entry_t        key, cur;
  logic [1:0]             status;
  logic                   masked;

  logic [LEN_W:0]         mid_sum;
  logic [LEN_W-1:0]       mid_c;
  logic [LEN_W-1:0]       cur_len;
  logic                   out_of_range;
  logic                   bigger;
  logic                   joins;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [SEQ_W-1:0] s,
                                                input logic [LEN_W-1:0] idx);
    return ADDR_W'(s) * ADDR_W'(MAX_AREAS) + ADDR_W'(idx[IDX_W-1:0]);
  endfunction

  assign mid_sum      = {1'b0, lo} + {1'b0, hi};
  assign mid_c        = mid_sum[LEN_W:1];
  assign cur_len      = lengths[cur_seq];
  assign out_of_range = item.seq_index >= act;
  assign bigger       = mem_rdata.start_pos > key.start_pos;
  // overlapping or touching: start <= end + 1
  assign joins = {1'b0, mem_rdata.start_pos} <= ({1'b0, cur.end_pos} + 32'd1);

  assign cmd_ready  = state == S_IDLE;
  assign done_valid = state == S_DONE;
  assign done_res   = '{status: status, masked: masked, total_count: total};

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_of(cur_seq, j);
    mem_wdata = key;
    mem_raddr = addr_of(cur_seq, i);
    case (state)
      S_INS: begin
        mem_waddr = addr_of(cur_seq, cur_len);
        mem_wdata = '{start_pos: item.begin_req, end_pos: item.finish};
        mem_we    = !out_of_range && (cur_len < LEN_W'(MAX_AREAS)) &&
                    (item.begin_req <= item.finish);
      end
      S_QTEST:  mem_raddr = addr_of(cur_seq, mid_c);
      S_CSTART: mem_raddr = addr_of(cur_seq, LEN_W'(1));
      S_SKGET:  mem_raddr = addr_of(cur_seq, i - LEN_W'(1));
      S_SPCHK: begin
        mem_raddr = addr_of(cur_seq, j - LEN_W'(2));
        mem_wdata = mem_rdata;
        mem_we    = bigger;
      end
      S_SPPUT: begin
        mem_we    = 1'b1;
        mem_raddr = (i + LEN_W'(1) < n) ? addr_of(cur_seq, i + LEN_W'(1))
                                        : addr_of(cur_seq, '0);
      end
      S_MGFST: mem_raddr = addr_of(cur_seq, LEN_W'(1));
      S_MGCHK: begin
        mem_raddr = addr_of(cur_seq, i + LEN_W'(1));
        mem_waddr = addr_of(cur_seq, w);
        mem_wdata = cur;
        mem_we    = !joins;
      end
      S_MGEND: begin
        mem_waddr = addr_of(cur_seq, w);
        mem_wdata = cur;
        mem_we    = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      total <= '0;
      for (int k = 0; k < NUM_SEQS; k++) begin
        lengths[k] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            item    <= cmd;
            cur_seq <= SEQ_W'(cmd.seq_index);
            status  <= imt_pkg::ST_OK;
            masked  <= 1'b0;
            case (cmd.func)
              imt_pkg::FN_INSERT: state <= S_INS;
              imt_pkg::FN_QUERY:  state <= S_QSTART;
              imt_pkg::FN_COMPACT: begin
                cur_seq <= '0;
                state   <= (act == '0) ? S_DONE : S_CSTART;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_INS: begin
          if (out_of_range) begin
            status <= imt_pkg::ST_RANGE;
          end else if (cur_len >= LEN_W'(MAX_AREAS)) begin
            status <= imt_pkg::ST_FULL;
          end else if (item.begin_req > item.finish) begin
            status <= imt_pkg::ST_ORDER;
          end else begin
            lengths[cur_seq] <= cur_len + LEN_W'(1);
            total            <= total + TW'(1);
          end
          state <= S_DONE;
        end
        S_QSTART: begin
          if (out_of_range) begin
            status <= imt_pkg::ST_RANGE;
            state  <= S_DONE;
          end else begin
            lo    <= '0;
            hi    <= cur_len;
            state <= S_QTEST;
          end
        end
        S_QTEST: begin
          if (lo < hi) begin
            mid   <= mid_c;
            state <= S_QCHK;
          end else begin
            state <= S_DONE;
          end
        end
        S_QCHK: begin
          if (item.query_position < mem_rdata.start_pos) begin
            hi    <= mid;
            state <= S_QTEST;
          end else if (item.query_position > mem_rdata.end_pos) begin
            lo    <= mid + LEN_W'(1);
            state <= S_QTEST;
          end else begin
            masked <= 1'b1;
            state  <= S_DONE;
          end
        end
        S_CSTART: begin
          n <= cur_len;
          i <= LEN_W'(1);
          // zero or one entry: nothing to sort or merge
          state <= (cur_len < LEN_W'(2)) ? S_NEXT : S_SKGET;
        end
        S_SKGET: begin
          key   <= mem_rdata;
          j     <= i;
          state <= S_SPCHK;
        end
        S_SPCHK: begin
          if (bigger) begin
            j <= j - LEN_W'(1);
            if (j == LEN_W'(1)) begin
              state <= S_SPPUT;
            end
          end else begin
            state <= S_SPPUT;
          end
        end
        S_SPPUT: begin
          if (i + LEN_W'(1) < n) begin
            i     <= i + LEN_W'(1);
            state <= S_SKGET;
          end else begin
            state <= S_MGFST;
          end
        end
        S_MGFST: begin
          // last key may have landed in entry 0 at the same edge it was read
          cur   <= (j == '0) ? key : mem_rdata;
          w     <= '0;
          i     <= LEN_W'(1);
          state <= S_MGCHK;
        end
        S_MGCHK: begin
          if (joins) begin
            if (mem_rdata.end_pos > cur.end_pos) begin
              cur.end_pos <= mem_rdata.end_pos;
            end
          end else begin
            w   <= w + LEN_W'(1);
            cur <= mem_rdata;
          end
          if (i + LEN_W'(1) < n) begin
            i <= i + LEN_W'(1);
          end else begin
            state <= S_MGEND;
          end
        end
        S_MGEND: begin
          lengths[cur_seq] <= w + LEN_W'(1);
          total            <= total - TW'(n) + TW'(w) + TW'(1);
          state            <= S_NEXT;
        end
        S_NEXT: begin
          if (({1'b0, cur_seq} + 1'b1) < act) begin
            cur_seq <= cur_seq + SEQ_W'(1);
            state   <= S_CSTART;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (done_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* sv/interval_mask_table.sv */
// Top level: register port, result register, sequencer and interval memory.
//
//   channel   | handshake          | payload
//   ----------+--------------------+-----------------------------
//   cmd       | cmd_valid/cmd_ready| imt_pkg::cmd_t
//   res       | res_valid/res_ready| imt_pkg::res_t
//   apb       | psel/penable/pready| paddr, pwdata, prdata
//
// One item at a time; the memory's registered read data sets the pace.
// Insert: a single write. Query: a binary search with one memory read per
// probe. Compact: per list, an in-place insertion sort, then a merge pass.
// No clearing pass after reset. A waiting result sits in the output register;
// the next item is accepted then.
module interval_mask_table #(
  parameter int NUM_SEQS  = imt_pkg::NUM_SEQS_DEF,
  parameter int MAX_AREAS = imt_pkg::MAX_AREAS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  imt_pkg::cmd_t                 cmd,
  output logic                          res_valid,
  input  logic                          res_ready,
  output imt_pkg::res_t                 res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [imt_pkg::PADDR_W-1:0]   paddr,
  input  logic [imt_pkg::PDATA_W-1:0]   pwdata,
  output logic [imt_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int ADDR_W = $clog2(NUM_SEQS * MAX_AREAS);
  localparam int ACT_W  = $clog2(NUM_SEQS + 1);
  localparam int CW     = imt_pkg::SEQ_CNT_W;

  logic [CW-1:0]       seq_count;
  logic [ACT_W-1:0]    act;
  logic                done_valid, done_ready;
  imt_pkg::res_t       done_res;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
  imt_pkg::entry_t     mem_wdata, mem_rdata;

  assign pready = 1'b1;
  assign prdata = (paddr == imt_pkg::ADDR_SEQ_COUNT) ?
                  imt_pkg::PDATA_W'(seq_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_count <= imt_pkg::SEQ_COUNT_RST;
    end else if (psel && penable && pwrite && paddr == imt_pkg::ADDR_SEQ_COUNT) begin
      seq_count <= pwdata[CW-1:0];
    end
  end

  // counts above NUM_SEQS act as NUM_SEQS
  assign act = (32'(seq_count) > NUM_SEQS) ? ACT_W'(NUM_SEQS) : ACT_W'(seq_count);

  assign done_ready = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (done_ready) begin
      res_valid <= done_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (done_ready && done_valid) begin
      res <= done_res;
    end
  end

  imt_ctrl #(
    .NUM_SEQS (NUM_SEQS),
    .MAX_AREAS(MAX_AREAS),
    .ADDR_W   (ADDR_W),
    .ACT_W    (ACT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .act       (act),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .done_valid(done_valid),
    .done_ready(done_ready),
    .done_res  (done_res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  imt_mem #(
    .DEPTH (NUM_SEQS * MAX_AREAS),
    .ADDR_W(ADDR_W)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("item accepted while another is in flight");

  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> !cmd_ready)
    else $error("memory written while idle");

  a_masked_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.masked |-> res.status == imt_pkg::ST_OK)
    else $error("masked result with error status");

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    done_valid && done_ready |=> res_valid)
    else $error("finished item not registered");
`endif

endmodule

/* tb/tb_top.sv */
// Testbench for interval_mask_table: directed and random items checked against a predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSEQ      = imt_pkg::NUM_SEQS_DEF;
  localparam int NAREA     = imt_pkg::MAX_AREAS_DEF;
  localparam int POS_W     = imt_pkg::POS_W;
  localparam int TOTAL_W   = imt_pkg::TOTAL_W;
  localparam int SEQ_CNT_W = imt_pkg::SEQ_CNT_W;
  localparam int STALL_MAX = 40000;
  localparam int HOLD_LEN  = 400;

  logic clk, rst;
  logic cmd_valid, cmd_ready, res_valid, res_ready;
  imt_pkg::cmd_t cmd;
  imt_pkg::res_t res;
  logic psel, penable, pwrite, pready;
  logic [imt_pkg::PADDR_W-1:0] paddr;
  logic [imt_pkg::PDATA_W-1:0] pwdata, prdata;

  interval_mask_table uut (.*);

  // predictor state
  logic [POS_W-1:0]     mask_start[NSEQ][NAREA];
  logic [POS_W-1:0]     mask_end[NSEQ][NAREA];
  int unsigned          list_len[NSEQ];
  logic [TOTAL_W-1:0]   mask_total;
  logic [SEQ_CNT_W-1:0] seq_cfg;

  imt_pkg::res_t expected_q[$];
  int   mismatches, n_insert, n_query, n_compact, n_results;
  int   burst_left;
  bit   long_hold;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned active_lists();
    return (seq_cfg > NSEQ) ? NSEQ : seq_cfg;
  endfunction

  function automatic void merge_list(int s);
    int unsigned n, w;
    logic [POS_W-1:0] ks, ke;
    int j;
    n = list_len[s];
    for (int i = 1; i < n; i++) begin
      ks = mask_start[s][i];
      ke = mask_end[s][i];
      j = i;
      while (j > 0 && mask_start[s][j-1] > ks) begin
        mask_start[s][j] = mask_start[s][j-1];
        mask_end[s][j] = mask_end[s][j-1];
        j--;
      end
      mask_start[s][j] = ks;
      mask_end[s][j] = ke;
    end
    if (n == 0) return;
    w = 0;
    for (int i = 1; i < n; i++) begin
      // touching intervals merge too, hence the +1
      if ({1'b0, mask_start[s][i]} <= {1'b0, mask_end[s][w]} + 32'd1) begin
        if (mask_end[s][i] > mask_end[s][w]) mask_end[s][w] = mask_end[s][i];
      end else begin
        w++;
        mask_start[s][w] = mask_start[s][i];
        mask_end[s][w] = mask_end[s][i];
      end
    end
    mask_total = mask_total - TOTAL_W'(n - (w + 1));
    list_len[s] = w + 1;
  endfunction

  function automatic bit lookup(int s, logic [POS_W-1:0] p);
    int unsigned lo, hi, mid;
    lo = 0;
    hi = list_len[s];
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (p < mask_start[s][mid]) hi = mid;
      else if (p > mask_end[s][mid]) lo = mid + 1;
      else return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic imt_pkg::res_t apply_item(imt_pkg::cmd_t c);
    imt_pkg::res_t r;
    int unsigned act;
    r = '0;
    act = active_lists();
    case (c.func)
      imt_pkg::FN_INSERT: begin
        n_insert++;
        if (c.seq_index >= act) r.status = imt_pkg::ST_RANGE;
        else if (list_len[c.seq_index] >= NAREA) r.status = imt_pkg::ST_FULL;
        else if (c.begin_req > c.finish) r.status = imt_pkg::ST_ORDER;
        else begin
          mask_start[c.seq_index][list_len[c.seq_index]] = c.begin_req;
          mask_end[c.seq_index][list_len[c.seq_index]] = c.finish;
          list_len[c.seq_index]++;
          mask_total++;
        end
      end
      imt_pkg::FN_COMPACT: begin
        n_compact++;
        for (int s = 0; s < act; s++) merge_list(s);
      end
      imt_pkg::FN_QUERY: begin
        n_query++;
        if (c.seq_index >= act) r.status = imt_pkg::ST_RANGE;
        else r.masked = lookup(c.seq_index, c.query_position);
      end
      default: ;
    endcase
    r.total_count = mask_total;
    return r;
  endfunction

  // sender: bursts of random length with random gaps; called at a clock edge
  task automatic send_item(imt_pkg::cmd_t c);
    if (burst_left == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                              : $urandom_range(1, 8);
    end
    burst_left--;
    cmd_valid <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    expected_q.push_back(apply_item(c));
  endtask

  task automatic drain();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_seq_count(logic [SEQ_CNT_W-1:0] v);
    drain();
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= imt_pkg::ADDR_SEQ_COUNT; pwdata <= imt_pkg::PDATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    seq_cfg = v;
  endtask

  function automatic imt_pkg::cmd_t mk(imt_pkg::func_t f, int s, logic [POS_W-1:0] b,
                                       logic [POS_W-1:0] e, logic [POS_W-1:0] q);
    imt_pkg::cmd_t c;
    c.func = f; c.seq_index = 2'(s);
    c.begin_req = b; c.finish = e; c.query_position = q;
    return c;
  endfunction

  function automatic logic [POS_W-1:0] rnd_pos();
    return POS_W'($urandom);
  endfunction

  task automatic test_directed();
    write_seq_count(3'd4);
    send_item(mk(imt_pkg::FN_INSERT, 0, 100, 200, rnd_pos()));
    send_item(mk(imt_pkg::FN_INSERT, 0, 10, 20, rnd_pos()));
    send_item(mk(imt_pkg::FN_INSERT, 0, 201, 300, 0));     // touches 100-200
    send_item(mk(imt_pkg::FN_INSERT, 0, 150, 160, '1));
    send_item(mk(imt_pkg::FN_INSERT, 1, 0, 0, 0));
    send_item(mk(imt_pkg::FN_INSERT, 3, '1, '1, '1));
    send_item(mk(imt_pkg::FN_INSERT, 2, 0, '1, 5));
    send_item(mk(imt_pkg::FN_INSERT, 2, 7, 6, 0));         // begin after end
    send_item(mk(imt_pkg::FN_QUERY, 0, '1, '1, 15));       // unsorted list
    send_item(mk(imt_pkg::FN_QUERY, 0, 0, 0, 250));
    send_item(mk(imt_pkg::FN_NOP, 1, '1, '1, '1));
    send_item(mk(imt_pkg::FN_COMPACT, 0, 0, 0, 0));
    send_item(mk(imt_pkg::FN_QUERY, 0, 0, 0, 300));
    send_item(mk(imt_pkg::FN_QUERY, 0, 0, 0, 301));
    send_item(mk(imt_pkg::FN_QUERY, 0, 0, 0, 9));
    send_item(mk(imt_pkg::FN_QUERY, 1, 0, 0, 0));
    send_item(mk(imt_pkg::FN_QUERY, 3, 0, 0, '1));
    send_item(mk(imt_pkg::FN_QUERY, 2, 0, 0, '1));
    write_seq_count(3'd0);                                 // no list in use
    send_item(mk(imt_pkg::FN_INSERT, 0, 1, 2, 0));
    send_item(mk(imt_pkg::FN_QUERY, 0, 0, 0, 150));
    send_item(mk(imt_pkg::FN_COMPACT, 0, 0, 0, 0));
    write_seq_count(3'd7);                                 // clamps to all lists
    send_item(mk(imt_pkg::FN_INSERT, 3, 5, 9, 0));
    send_item(mk(imt_pkg::FN_QUERY, 3, 0, 0, 7));
    write_seq_count(3'd2);
    send_item(mk(imt_pkg::FN_INSERT, 2, 5, 9, 0));
    send_item(mk(imt_pkg::FN_QUERY, 3, 0, 0, 7));
  endtask

  // fill one list to capacity with touching intervals, then collapse it
  task automatic test_full_list();
    write_seq_count(3'd2);
    for (int k = list_len[1]; k < NAREA; k++)
      send_item(mk(imt_pkg::FN_INSERT, 1, POS_W'(5000 + 2*k), POS_W'(5001 + 2*k), 0));
    send_item(mk(imt_pkg::FN_INSERT, 1, 1, 1, 0));
    send_item(mk(imt_pkg::FN_INSERT, 1, 9, 3, 0));         // full wins over order
    send_item(mk(imt_pkg::FN_COMPACT, 0, 0, 0, 0));
    send_item(mk(imt_pkg::FN_QUERY, 1, 0, 0, 6000));
  endtask

  task automatic test_backpressure();
    imt_pkg::cmd_t c;
    long_hold = 1'b1;
    for (int k = 0; k < 30; k++) begin
      c = mk(($urandom_range(0, 1) == 0) ? imt_pkg::FN_INSERT : imt_pkg::FN_QUERY,
             $urandom_range(0, 1), 0, 0, POS_W'($urandom_range(0, 3000)));
      c.begin_req = POS_W'($urandom_range(0, 3000));
      c.finish = c.begin_req + POS_W'($urandom_range(0, 50));
      send_item(c);
    end
  endtask

  task automatic test_random(int count);
    imt_pkg::cmd_t c;
    int s, k, pick;
    logic [POS_W-1:0] b;
    for (int n = 0; n < count; n++) begin
      if (n % 80 == 79) begin
        pick = $urandom_range(0, 5);
        write_seq_count(pick == 5 ? 3'($urandom_range(5, 7)) : 3'(pick));
      end
      s = $urandom_range(0, 3);
      pick = $urandom_range(0, 99);
      c = mk(imt_pkg::FN_INSERT, s, 0, 0, rnd_pos());
      if (pick < 48) begin
        b = ($urandom_range(0, 9) == 0) ? rnd_pos() : POS_W'($urandom_range(0, 20000));
        c.begin_req = b;
        c.finish = ($urandom_range(0, 11) == 0) ? rnd_pos() : b + POS_W'($urandom_range(0, 400));
        if (c.finish < b) c.finish = '1;
        if ($urandom_range(0, 15) == 0) begin
          c.begin_req = c.finish + 1'b1;
          if (c.begin_req == 0) c.begin_req = '1;
          if (c.begin_req == c.finish) c.finish = c.finish - 1'b1;
        end
      end else if (pick < 55) begin
        c.func = imt_pkg::FN_COMPACT;
      end else if (pick < 97) begin
        c.func = imt_pkg::FN_QUERY;
        if (list_len[s] != 0 && $urandom_range(0, 4) != 0) begin
          k = $urandom_range(0, list_len[s] - 1);
          case ($urandom_range(0, 3))
            0: c.query_position = mask_start[s][k] - 1'b1;
            1: c.query_position = mask_start[s][k];
            2: c.query_position = mask_end[s][k];
            default: c.query_position = mask_end[s][k] + 1'b1;
          endcase
        end else if ($urandom_range(0, 1) == 0) begin
          c.query_position = POS_W'($urandom_range(0, 20000));
        end
      end else begin
        c.func = imt_pkg::FN_NOP;
        c.begin_req = rnd_pos(); c.finish = rnd_pos();
      end
      send_item(c);
    end
  endtask

  // receiver: own stall pattern, plus one long hold-off on request
  initial begin
    int len, mode;
    res_ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        res_ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        long_hold = 1'b0;
      end
      len = $urandom_range(1, 40);
      mode = $urandom_range(0, 2);
      for (int i = 0; i < len; i++) begin
        case (mode)
          0: res_ready <= 1'b1;
          1: res_ready <= ($urandom_range(0, 1) == 1);
          default: res_ready <= (i >= len / 2);
        endcase
        if (i != len - 1) @(posedge clk);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    imt_pkg::res_t e;
    if (!rst && res_valid && res_ready) begin
      n_results++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %p", res);
      end else begin
        e = expected_q.pop_front();
        if (res.status !== e.status || res.masked !== e.masked ||
            res.total_count !== e.total_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: status %0d/%0d masked %0d/%0d total %0d/%0d (exp/act)",
                     e.status, res.status, e.masked, res.masked,
                     e.total_count, res.total_count);
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((cmd_valid && cmd_ready) || (res_valid && res_ready) || psel) idle = 0;
      else idle++;
      if (idle >= STALL_MAX) begin
        $display("timeout after %0d idle cycles", idle);
        $display("interval_mask_table verification failed");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    cmd_valid = 1'b0; cmd = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    seq_cfg = imt_pkg::SEQ_COUNT_RST;
    mask_total = '0;
    for (int s = 0; s < NSEQ; s++) list_len[s] = 0;
    mismatches = 0; n_insert = 0; n_query = 0; n_compact = 0; n_results = 0;
    burst_left = 0; long_hold = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_list();
    test_backpressure();
    test_random(320);
    drain();
    $display("covered %0d inserts, %0d queries, %0d compactions; %0d results checked",
             n_insert, n_query, n_compact, n_results);
    $display("including a full list, seq_count 0 to 7 and a long output stall");
    if (mismatches == 0 && expected_q.size() == 0)
      $display("interval_mask_table verification clean");
    else
      $display("interval_mask_table verification failed");
    $finish;
  end

endmodule
